### rtl/core/a64af_pkg.sv
package a64af_pkg;

  // Default sizes of the architectural state.
  localparam int NUM_GP_REGS = 31;
  localparam int DATA_WIDTH  = 64;

  // Field widths of one decoded add.
  localparam int REG_NUM_W = 6;
  localparam int IMM_W     = 24;
  localparam int AMOUNT_W  = 6;

  // Request types.
  localparam logic [1:0] REQ_IMM   = 2'd0;
  localparam logic [1:0] REQ_SHIFT = 2'd1;
  localparam logic [1:0] REQ_EXT   = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Shift kinds for the shifted register form.
  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;

  // Source sizes for the extended register form (low two bits of the kind).
  localparam logic [1:0] EXT_BYTE   = 2'd0;
  localparam logic [1:0] EXT_HALF   = 2'd1;
  localparam logic [1:0] EXT_WORD   = 2'd2;
  localparam logic [1:0] EXT_DOUBLE = 2'd3;

  // Operation controls carried from the input into the execute stage.
  typedef struct packed {
    logic [1:0]          req_type;
    logic                is_32bit;
    logic                set_flags;
    logic [IMM_W-1:0]    immediate;
    logic [1:0]          shift_kind;
    logic [2:0]          extend_kind;
    logic [AMOUNT_W-1:0] amount;
  } a64af_op_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } a64af_flags_t;

endpackage

### rtl/core/a64_add_flags_unit.sv
// Executes one decoded AArch64 add per item (immediate, shifted register or
// extended register, 32 or 64 bits wide) against an internal register file of
// general registers plus the stack pointer, and keeps the NZCV flags. Items are
// taken at a sustained rate of one per cycle unless a stalled result holds the
// output, with no bubbles between dependent adds. Each accepted item first reads
// both source registers from the register file memories; the execute stage then
// forms the operands, adds, updates the flags, writes the destination back and
// registers the result. That read-then-write loop through the register file
// sets the rate, and the write of the previous item is forwarded to the next one
// so the loop closes with no bubble. Register number 31 addresses the stack
// pointer and 32 or above the zero register, which reads as zero and drops
// writes. An unsupported request changes no register or flag, reports a zero
// sum, and returns the instruction address itself as the next pc. Registers
// read as zero after reset without any clearing pass.
module a64_add_flags_unit #(
  parameter int NUM_GP_REGS = a64af_pkg::NUM_GP_REGS,
  parameter int DATA_WIDTH  = a64af_pkg::DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_req_type,
  input  logic                             in_is_32bit,
  input  logic                             in_set_flags,
  input  logic [a64af_pkg::REG_NUM_W-1:0]  in_dest_reg,
  input  logic [a64af_pkg::REG_NUM_W-1:0]  in_first_reg,
  input  logic [a64af_pkg::REG_NUM_W-1:0]  in_second_reg,
  input  logic [a64af_pkg::IMM_W-1:0]      in_immediate,
  input  logic [1:0]                       in_shift_kind,
  input  logic [2:0]                       in_extend_kind,
  input  logic [a64af_pkg::AMOUNT_W-1:0]   in_amount,
  input  logic [DATA_WIDTH-1:0]            in_instr_addr,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_supported,
  output logic [DATA_WIDTH-1:0]            out_sum_value,
  output logic                             out_flag_n,
  output logic                             out_flag_z,
  output logic                             out_flag_c,
  output logic                             out_flag_v,
  output logic [DATA_WIDTH-1:0]            out_next_pc
);

  // The stack pointer lives in the entry just above the general registers.
  localparam int RF_DEPTH = NUM_GP_REGS + 1;
  localparam int RF_AW    = $clog2(RF_DEPTH);
  localparam logic [a64af_pkg::REG_NUM_W-1:0] LAST_REG =
    a64af_pkg::REG_NUM_W'(NUM_GP_REGS);

  // Handshake and stage control.
  logic in_acc;
  logic s1_adv;
  logic s1_fire;

  // Execute stage holding registers.
  logic                                  s1_vld_r;
  a64af_pkg::a64af_op_t                  s1_op_r;
  logic [a64af_pkg::REG_NUM_W-1:0]       s1_dest_r;
  logic [a64af_pkg::REG_NUM_W-1:0]       s1_first_r;
  logic [a64af_pkg::REG_NUM_W-1:0]       s1_second_r;
  logic [DATA_WIDTH-1:0]                 s1_addr_r;
  a64af_pkg::a64af_op_t                  in_op;

  // Register file state.
  logic [RF_DEPTH-1:0]   ent_vld_r;
  logic [DATA_WIDTH-1:0] rn_ram;
  logic [DATA_WIDTH-1:0] rm_ram;
  logic                  fwd_vld_r;
  logic [RF_AW-1:0]      fwd_addr_r;
  logic [DATA_WIDTH-1:0] fwd_data_r;

  // Operand selection and write-back.
  logic [RF_AW-1:0]      rn_idx;
  logic [RF_AW-1:0]      rm_idx;
  logic [RF_AW-1:0]      rd_idx;
  logic [DATA_WIDTH-1:0] rn_val;
  logic [DATA_WIDTH-1:0] rm_val;
  logic                  wr_en;

  // Execute results and flags.
  logic                    alu_ok;
  logic [DATA_WIDTH-1:0]   alu_sum;
  a64af_pkg::a64af_flags_t alu_flags;
  a64af_pkg::a64af_flags_t nzcv_r;
  logic [DATA_WIDTH-1:0]   next_pc;

  // Output register.
  logic                    out_vld_r;
  logic                    out_ok_r;
  logic [DATA_WIDTH-1:0]   out_sum_r;
  a64af_pkg::a64af_flags_t out_flags_r;
  logic [DATA_WIDTH-1:0]   out_pc_r;

  // The execute stage moves on whenever the output register is free or being
  // emptied this cycle, so only a result held by a stalled output blocks the next item.
  assign s1_adv   = !out_vld_r || !out_stall;
  assign s1_fire  = s1_vld_r && s1_adv;
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_op.req_type    = in_req_type;
    in_op.is_32bit    = in_is_32bit;
    in_op.set_flags   = in_set_flags;
    in_op.immediate   = in_immediate;
    in_op.shift_kind  = in_shift_kind;
    in_op.extend_kind = in_extend_kind;
    in_op.amount      = in_amount;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= in_op;
      s1_dest_r   <= in_dest_reg;
      s1_first_r  <= in_first_reg;
      s1_second_r <= in_second_reg;
      s1_addr_r   <= in_instr_addr;
    end
  end

  // Two copies of the register file give the two read ports. Both take the
  // same write. The read data only changes when a new item is accepted, so it
  // holds while the execute stage is stalled.
  assign rd_idx = s1_dest_r[RF_AW-1:0];
  assign wr_en  = s1_fire && alu_ok && (s1_dest_r <= LAST_REG);

  a64af_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (RF_DEPTH)
  ) u_rf_rn (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd_idx),
    .wdata (alu_sum),
    .re    (in_acc),
    .raddr (in_first_reg[RF_AW-1:0]),
    .rdata (rn_ram)
  );

  a64af_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (RF_DEPTH)
  ) u_rf_rm (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd_idx),
    .wdata (alu_sum),
    .re    (in_acc),
    .raddr (in_second_reg[RF_AW-1:0]),
    .rdata (rm_ram)
  );

  // Entries that were never written read as zero, which stands in for the
  // cleared register file after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      fwd_vld_r <= 1'b0;
    end else if (wr_en) begin
      ent_vld_r[rd_idx] <= 1'b1;
      fwd_vld_r         <= 1'b1;
    end
  end

  // The last write is kept so an item whose read raced that write sees it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= rd_idx;
      fwd_data_r <= alu_sum;
    end
  end

  assign rn_idx = s1_first_r[RF_AW-1:0];
  assign rm_idx = s1_second_r[RF_AW-1:0];

  always_comb begin
    if (s1_first_r > LAST_REG) begin
      rn_val = '0;
    end else if (fwd_vld_r && (fwd_addr_r == rn_idx)) begin
      rn_val = fwd_data_r;
    end else if (ent_vld_r[rn_idx]) begin
      rn_val = rn_ram;
    end else begin
      rn_val = '0;
    end

    if (s1_second_r > LAST_REG) begin
      rm_val = '0;
    end else if (fwd_vld_r && (fwd_addr_r == rm_idx)) begin
      rm_val = fwd_data_r;
    end else if (ent_vld_r[rm_idx]) begin
      rm_val = rm_ram;
    end else begin
      rm_val = '0;
    end
  end

  a64af_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .op        (s1_op_r),
    .lhs_raw   (rn_val),
    .rhs_raw   (rm_val),
    .flags_in  (nzcv_r),
    .supported (alu_ok),
    .sum       (alu_sum),
    .flags_out (alu_flags)
  );

  // A supported add steps past the instruction; an unsupported one stays on it.
  assign next_pc = alu_ok ? (s1_addr_r + DATA_WIDTH'(4)) : s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nzcv_r <= '0;
    end else if (s1_fire) begin
      nzcv_r <= alu_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_ok_r    <= alu_ok;
      out_sum_r   <= alu_sum;
      out_flags_r <= alu_flags;
      out_pc_r    <= next_pc;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_supported = out_ok_r;
  assign out_sum_value = out_sum_r;
  assign out_flag_n    = out_flags_r.n;
  assign out_flag_z    = out_flags_r.z;
  assign out_flag_c    = out_flags_r.c;
  assign out_flag_v    = out_flags_r.v;
  assign out_next_pc   = out_pc_r;

  // An item in the execute stage is never dropped while its result cannot leave.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_vld_r && out_stall |=> s1_vld_r)
    else $error("execute stage item lost while output stalled");

  // An unsupported item reports a zero sum and leaves the flags alone.
  a_unsupported: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_op_r.req_type == a64af_pkg::REQ_NONE)
    |=> (out_sum_value == '0) && !out_supported && $stable(nzcv_r))
    else $error("unsupported item changed state or reported a sum");

  // Flags stay put for an item that does not ask for them.
  a_flags_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_op_r.set_flags |=> $stable(nzcv_r))
    else $error("flags changed without a flag-setting item");

  // A register write is visible through the forwarding path on the next cycle.
  a_fwd_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> fwd_vld_r && ent_vld_r[fwd_addr_r] && (fwd_data_r == $past(alu_sum)))
    else $error("forwarding register does not track the last write");

endmodule

### rtl/core/a64af_ram.sv
module a64af_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/a64af_alu.sv
module a64af_alu #(
  parameter int DATA_WIDTH = a64af_pkg::DATA_WIDTH
) (
  input  a64af_pkg::a64af_op_t    op,
  input  logic [DATA_WIDTH-1:0]   lhs_raw,
  input  logic [DATA_WIDTH-1:0]   rhs_raw,
  input  a64af_pkg::a64af_flags_t flags_in,
  output logic                    supported,
  output logic [DATA_WIDTH-1:0]   sum,
  output a64af_pkg::a64af_flags_t flags_out
);

  localparam int HALF = DATA_WIDTH / 2;

  logic [DATA_WIDTH-1:0] mask;
  logic [DATA_WIDTH-1:0] lhs;
  logic [DATA_WIDTH-1:0] rv;
  logic                  sgn;
  logic [DATA_WIDTH-1:0] sfill;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH-1:0] ext;
  logic [DATA_WIDTH-1:0] ext_sh;
  logic [DATA_WIDTH-1:0] rhs;
  logic [DATA_WIDTH:0]   sum_w;
  logic [DATA_WIDTH-1:0] res;
  logic [DATA_WIDTH-1:0] ovf;
  a64af_pkg::a64af_flags_t flags_new;

  always_comb begin
    mask  = op.is_32bit ? {{HALF{1'b0}}, {HALF{1'b1}}} : {DATA_WIDTH{1'b1}};
    lhs   = lhs_raw & mask;
    rv    = rhs_raw & mask;
    sgn   = op.is_32bit ? rv[HALF-1] : rv[DATA_WIDTH-1];
    sfill = op.is_32bit ? {{HALF{sgn}}, rv[HALF-1:0]} : rv;

    case (op.shift_kind)
      a64af_pkg::SHIFT_LSL: shifted = (rv << op.amount) & mask;
      a64af_pkg::SHIFT_LSR: shifted = rv >> op.amount;
      a64af_pkg::SHIFT_ASR: shifted = DATA_WIDTH'($unsigned($signed(sfill) >>> op.amount)) & mask;
      default:              shifted = rv;
    endcase

    // Sign or zero extend (bit 2) to the full word; mask trims to operand size.
    case (op.extend_kind[1:0])
      a64af_pkg::EXT_BYTE:
        ext = op.extend_kind[2] ? {{(DATA_WIDTH-8){rv[7]}}, rv[7:0]} : DATA_WIDTH'(rv[7:0]);
      a64af_pkg::EXT_HALF:
        ext = op.extend_kind[2] ? {{(DATA_WIDTH-16){rv[15]}}, rv[15:0]}
                                : DATA_WIDTH'(rv[15:0]);
      a64af_pkg::EXT_WORD:
        ext = op.extend_kind[2] ? {{(DATA_WIDTH-32){rv[31]}}, rv[31:0]}
                                : DATA_WIDTH'(rv[31:0]);
      default:
        ext = rv;
    endcase
    ext_sh = ((ext & mask) << op.amount) & mask;

    case (op.req_type)
      a64af_pkg::REQ_IMM:   rhs = DATA_WIDTH'(op.immediate) & mask;
      a64af_pkg::REQ_SHIFT: rhs = shifted;
      default:              rhs = ext_sh;
    endcase

    sum_w = {1'b0, lhs} + {1'b0, rhs};
    res   = sum_w[DATA_WIDTH-1:0] & mask;
    ovf   = ~(lhs ^ rhs) & (res ^ lhs);

    flags_new.n = op.is_32bit ? res[HALF-1] : res[DATA_WIDTH-1];
    flags_new.z = (res == '0);
    flags_new.c = op.is_32bit ? sum_w[HALF] : sum_w[DATA_WIDTH];
    flags_new.v = op.is_32bit ? ovf[HALF-1] : ovf[DATA_WIDTH-1];

    supported = (op.req_type != a64af_pkg::REQ_NONE);
    sum       = supported ? res : '0;
    flags_out = (supported && op.set_flags) ? flags_new : flags_in;
  end

endmodule

### sim/a64_add_flags_checker.sv
`timescale 1ns / 100ps

module a64_add_flags_checker (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic                            in_is_32bit,
  input  logic                            in_set_flags,
  input  logic [a64af_pkg::REG_NUM_W-1:0] in_dest_reg,
  input  logic [a64af_pkg::REG_NUM_W-1:0] in_first_reg,
  input  logic [a64af_pkg::REG_NUM_W-1:0] in_second_reg,
  input  logic [a64af_pkg::IMM_W-1:0]     in_immediate,
  input  logic [1:0]                      in_shift_kind,
  input  logic [2:0]                      in_extend_kind,
  input  logic [a64af_pkg::AMOUNT_W-1:0]  in_amount,
  input  logic [63:0]                     in_instr_addr,

  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_supported,
  input  logic [63:0]                     out_sum_value,
  input  logic                            out_flag_n,
  input  logic                            out_flag_z,
  input  logic                            out_flag_c,
  input  logic                            out_flag_v,
  input  logic [63:0]                     out_next_pc,

  output int                              fail_count,
  output int                              results_seen,
  output int                              pending
);

  import a64af_pkg::*;

  localparam logic [REG_NUM_W-1:0] SP_REG = NUM_GP_REGS;
  localparam int                   MAX_REPORTS = 200;

  typedef struct packed {
    logic         supported;
    logic [63:0]  sum;
    a64af_flags_t flags;
    logic [63:0]  next_pc;
  } add_outcome_t;

  // Architectural state as the block should see it.
  logic [63:0]  gpr_file [NUM_GP_REGS];
  logic [63:0]  stack_value;
  a64af_flags_t flag_state;
  logic [63:0]  pc_value;

  add_outcome_t outcome_q [$];
  int           errors   = 0;
  int           compared = 0;

  initial begin
    fail_count   = 0;
    results_seen = 0;
    pending      = 0;
  end

  function automatic logic [63:0] low_mask(int bits);
    return (bits >= 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
  endfunction

  function automatic logic [63:0] read_source(logic [REG_NUM_W-1:0] r, int bits);
    logic [63:0] v;
    if (r < NUM_GP_REGS) v = gpr_file[r];
    else if (r == SP_REG) v = stack_value;
    else v = '0;
    return v & low_mask(bits);
  endfunction

  function automatic logic [63:0] shift_value(logic [63:0] v, logic [1:0] kind,
                                              logic [AMOUNT_W-1:0] amt, int bits);
    logic [63:0] m;
    logic        neg;
    m   = low_mask(bits);
    neg = v[bits-1];
    v   = v & m;
    if (amt == 0) return v;
    case (kind)
      SHIFT_LSL: return (amt >= bits) ? 64'd0 : ((v << amt) & m);
      SHIFT_LSR: return (amt >= bits) ? 64'd0 : (v >> amt);
      SHIFT_ASR: begin
        if (amt >= bits) return neg ? m : 64'd0;
        if (neg) return ((v >> amt) | ~(m >> amt)) & m;
        return v >> amt;
      end
      default: return v;
    endcase
  endfunction

  function automatic logic [63:0] extend_value(logic [63:0] v, logic [2:0] kind,
                                               logic [AMOUNT_W-1:0] amt, int bits);
    int          sz;
    logic [63:0] e;
    case (kind[1:0])
      EXT_BYTE: sz = 8;
      EXT_HALF: sz = 16;
      EXT_WORD: sz = 32;
      default:  sz = 64;
    endcase
    if (sz > bits) sz = bits;
    e = v & low_mask(sz);
    if (kind[2] && sz < 64 && e[sz-1]) e = e | ~low_mask(sz);
    e = e & low_mask(bits);
    return shift_value(e, SHIFT_LSL, amt, bits);
  endfunction

  // Executes one add against the tracked state and returns what the block reports.
  function automatic add_outcome_t execute_add(
    logic [1:0] req, logic is_32, logic setf, logic [REG_NUM_W-1:0] rd,
    logic [REG_NUM_W-1:0] rn, logic [REG_NUM_W-1:0] rm, logic [IMM_W-1:0] imm,
    logic [1:0] shk, logic [2:0] exk, logic [AMOUNT_W-1:0] amt, logic [63:0] addr);
    int           bits;
    logic [63:0]  m, lhs, rhs, total, top;
    add_outcome_t o;
    bits  = is_32 ? 32 : DATA_WIDTH;
    m     = low_mask(bits);
    total = '0;
    if (req != REQ_NONE) begin
      lhs = read_source(rn, bits);
      case (req)
        REQ_IMM:   rhs = {{(64-IMM_W){1'b0}}, imm} & m;
        REQ_SHIFT: rhs = shift_value(read_source(rm, bits), shk, amt, bits);
        default:   rhs = extend_value(read_source(rm, bits), exk, amt, bits);
      endcase
      total = (lhs + rhs) & m;
      if (rd < NUM_GP_REGS) gpr_file[rd] = total;
      else if (rd == SP_REG) stack_value = total;
      if (setf) begin
        top          = 64'd1 << (bits - 1);
        flag_state.n = |(total & top);
        flag_state.z = (total == 64'd0);
        flag_state.c = (total < lhs);
        flag_state.v = |(~(lhs ^ rhs) & (total ^ lhs) & top);
      end
      pc_value = addr + 64'd4;
    end else begin
      pc_value = addr;
    end
    o.supported = (req != REQ_NONE);
    o.sum       = total;
    o.flags     = flag_state;
    o.next_pc   = pc_value;
    return o;
  endfunction

  task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    add_outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_GP_REGS; i++) gpr_file[i] = '0;
      stack_value = '0;
      flag_state  = '0;
      pc_value    = '0;
      outcome_q.delete();
    end else begin
      // Results first: an item taken at this edge cannot have its result out yet.
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t ns: result with no item pending, actual sum %h pc %h",
                   $time, out_sum_value, out_next_pc);
        end else begin
          want = outcome_q.pop_front();
          compared++;
          check_field("supported", 64'(want.supported), 64'(out_supported));
          check_field("sum_value", want.sum, out_sum_value);
          check_field("flag_n", 64'(want.flags.n), 64'(out_flag_n));
          check_field("flag_z", 64'(want.flags.z), 64'(out_flag_z));
          check_field("flag_c", 64'(want.flags.c), 64'(out_flag_c));
          check_field("flag_v", 64'(want.flags.v), 64'(out_flag_v));
          check_field("next_pc", want.next_pc, out_next_pc);
        end
      end
      if (in_valid && !in_stall)
        outcome_q.push_back(execute_add(in_req_type, in_is_32bit, in_set_flags,
                                        in_dest_reg, in_first_reg, in_second_reg,
                                        in_immediate, in_shift_kind, in_extend_kind,
                                        in_amount, in_instr_addr));
    end
    fail_count   <= errors;
    results_seen <= compared;
    pending      <= outcome_q.size();
  end

endmodule

### sim/a64_add_flags_unit_tb.sv
`timescale 1ns / 100ps

module a64_add_flags_unit_tb;

  import a64af_pkg::*;

  // The run is short; the limit sits far above the slowest legal pace.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 640;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 20;

  // Register 31 is the stack pointer and the next number the zero register.
  localparam logic [REG_NUM_W-1:0] SP_REG = NUM_GP_REGS;
  localparam logic [REG_NUM_W-1:0] ZR_REG = NUM_GP_REGS + 1;

  typedef struct packed {
    logic [1:0]           req_type;
    logic                 is_32bit;
    logic                 set_flags;
    logic [REG_NUM_W-1:0] dest_reg;
    logic [REG_NUM_W-1:0] first_reg;
    logic [REG_NUM_W-1:0] second_reg;
    logic [IMM_W-1:0]     immediate;
    logic [1:0]           shift_kind;
    logic [2:0]           extend_kind;
    logic [AMOUNT_W-1:0]  amount;
    logic [63:0]          instr_addr;
  } add_item_t;

  // Every block input starts at a known value.
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic [1:0]           in_req_type    = REQ_IMM;
  logic                 in_is_32bit    = 1'b0;
  logic                 in_set_flags   = 1'b0;
  logic [REG_NUM_W-1:0] in_dest_reg    = '0;
  logic [REG_NUM_W-1:0] in_first_reg   = '0;
  logic [REG_NUM_W-1:0] in_second_reg  = '0;
  logic [IMM_W-1:0]     in_immediate   = '0;
  logic [1:0]           in_shift_kind  = SHIFT_LSL;
  logic [2:0]           in_extend_kind = '0;
  logic [AMOUNT_W-1:0]  in_amount      = '0;
  logic [63:0]          in_instr_addr  = '0;
  logic                 out_stall      = 1'b0;

  logic                 in_stall;
  logic                 out_valid;
  logic                 out_supported;
  logic [63:0]          out_sum_value;
  logic                 out_flag_n;
  logic                 out_flag_z;
  logic                 out_flag_c;
  logic                 out_flag_v;
  logic [63:0]          out_next_pc;

  int fail_count;
  int results_seen;
  int pending;

  // Idle percentages of the sender and the receiver for the current phase.
  int send_idle_pct = 31;
  int recv_idle_pct = 53;
  // The stimulus asks for a long output hold-off by bumping holds_asked.
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int directed_sent = 0;
  int random_sent   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  a64_add_flags_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_is_32bit    (in_is_32bit),
    .in_set_flags   (in_set_flags),
    .in_dest_reg    (in_dest_reg),
    .in_first_reg   (in_first_reg),
    .in_second_reg  (in_second_reg),
    .in_immediate   (in_immediate),
    .in_shift_kind  (in_shift_kind),
    .in_extend_kind (in_extend_kind),
    .in_amount      (in_amount),
    .in_instr_addr  (in_instr_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_supported  (out_supported),
    .out_sum_value  (out_sum_value),
    .out_flag_n     (out_flag_n),
    .out_flag_z     (out_flag_z),
    .out_flag_c     (out_flag_c),
    .out_flag_v     (out_flag_v),
    .out_next_pc    (out_next_pc)
  );

  // The checker sits beside the block and watches both channels.
  a64_add_flags_checker watcher (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_is_32bit    (in_is_32bit),
    .in_set_flags   (in_set_flags),
    .in_dest_reg    (in_dest_reg),
    .in_first_reg   (in_first_reg),
    .in_second_reg  (in_second_reg),
    .in_immediate   (in_immediate),
    .in_shift_kind  (in_shift_kind),
    .in_extend_kind (in_extend_kind),
    .in_amount      (in_amount),
    .in_instr_addr  (in_instr_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_supported  (out_supported),
    .out_sum_value  (out_sum_value),
    .out_flag_n     (out_flag_n),
    .out_flag_z     (out_flag_z),
    .out_flag_c     (out_flag_c),
    .out_flag_v     (out_flag_v),
    .out_next_pc    (out_next_pc),
    .fail_count     (fail_count),
    .results_seen   (results_seen),
    .pending        (pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver. A requested hold-off keeps stall high without a break, counted
  // down here in hold_left, while the sender keeps offering items so the block
  // backs up and stalls its input. Otherwise the stall is random at the phase's rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic add_item_t make_item(
    logic [1:0] req, logic is_32, logic setf, logic [REG_NUM_W-1:0] rd,
    logic [REG_NUM_W-1:0] rn, logic [REG_NUM_W-1:0] rm, logic [IMM_W-1:0] imm,
    logic [1:0] shk, logic [2:0] exk, logic [AMOUNT_W-1:0] amt);
    add_item_t it;
    it.req_type    = req;
    it.is_32bit    = is_32;
    it.set_flags   = setf;
    it.dest_reg    = rd;
    it.first_reg   = rn;
    it.second_reg  = rm;
    it.immediate   = imm;
    it.shift_kind  = shk;
    it.extend_kind = exk;
    it.amount      = amt;
    it.instr_addr  = '0;
    return it;
  endfunction

  // Register numbers lean on a small working set so results feed later adds,
  // with the stack pointer, the zero register and out-of-range numbers mixed in.
  function automatic logic [REG_NUM_W-1:0] pick_reg();
    int r;
    r = $urandom_range(99);
    if (r < 60) return REG_NUM_W'($urandom_range(7));
    if (r < 72) return SP_REG;
    if (r < 84) return ZR_REG;
    return REG_NUM_W'($urandom_range(63));
  endfunction

  function automatic add_item_t random_item();
    add_item_t it;
    int        pick;
    it.req_type    = ($urandom_range(99) < 6) ? REQ_NONE : 2'($urandom_range(2));
    it.is_32bit    = 1'($urandom_range(1));
    it.set_flags   = 1'($urandom_range(1));
    it.dest_reg    = pick_reg();
    it.first_reg   = pick_reg();
    it.second_reg  = pick_reg();
    pick = $urandom_range(3);
    if (pick == 0) it.immediate = IMM_W'($urandom_range(15));
    else if (pick == 1) it.immediate = {IMM_W{1'b1}};
    else it.immediate = IMM_W'($urandom);
    // Shift kind three is outside the named kinds but still has to pass through.
    it.shift_kind  = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    it.extend_kind = 3'($urandom_range(7));
    it.amount      = $urandom_range(1) ? AMOUNT_W'($urandom_range(4))
                                       : AMOUNT_W'($urandom_range(63));
    if ($urandom_range(9) == 0)
      it.instr_addr = {32'hFFFF_FFFF, 28'hFFF_FFFF, 4'($urandom_range(15))};
    else
      it.instr_addr = {$urandom, $urandom};
    return it;
  endfunction

  // Offers one item after an optional random gap and holds it until taken.
  // Valid is raised without looking at stall, and the payload stays put
  // while the block stalls it.
  task automatic send_item(add_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= it.req_type;
    in_is_32bit    <= it.is_32bit;
    in_set_flags   <= it.set_flags;
    in_dest_reg    <= it.dest_reg;
    in_first_reg   <= it.first_reg;
    in_second_reg  <= it.second_reg;
    in_immediate   <= it.immediate;
    in_shift_kind  <= it.shift_kind;
    in_extend_kind <= it.extend_kind;
    in_amount      <= it.amount;
    in_instr_addr  <= it.instr_addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    add_item_t directed_list [$];
    add_item_t it;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. It builds extreme operand values in the registers
    // step by step and then uses them to hit each flag, the large-shift
    // rules, every extend and the special registers.
    // Unsupported request straight after reset.
    directed_list.push_back(make_item(REQ_NONE, 0, 1, 0, 0, 0, '1, SHIFT_LSL, 0, 0));
    // x0 = largest immediate, x1 = x0 + (x0 << 40).
    directed_list.push_back(make_item(REQ_IMM, 0, 1, 0, ZR_REG, 0, '1, SHIFT_LSL, 0, 0));
    directed_list.push_back(make_item(REQ_SHIFT, 0, 1, 1, 0, 0, 0, SHIFT_LSL, 0, 40));
    // Top bit only, then sign fill to all ones with an arithmetic shift by 63.
    directed_list.push_back(make_item(REQ_SHIFT, 0, 1, 2, ZR_REG, 0, 0, SHIFT_LSL, 0, 63));
    directed_list.push_back(make_item(REQ_SHIFT, 0, 1, 3, ZR_REG, 2, 0, SHIFT_ASR, 0, 63));
    // All ones plus all ones sets the carry.
    directed_list.push_back(make_item(REQ_SHIFT, 0, 1, 4, 3, 3, 0, SHIFT_LSL, 0, 0));
    // Thirty-two-bit operands take only the low word.
    directed_list.push_back(make_item(REQ_SHIFT, 1, 1, 5, 2, 3, 0, SHIFT_LSL, 0, 0));
    // Largest positive word, then one more gives signed overflow.
    directed_list.push_back(make_item(REQ_SHIFT, 1, 1, 6, ZR_REG, 3, 0, SHIFT_LSR, 0, 1));
    directed_list.push_back(make_item(REQ_IMM, 1, 1, 7, 6, 0, 1, SHIFT_LSL, 0, 0));
    // The same overflow at full width.
    directed_list.push_back(make_item(REQ_SHIFT, 0, 1, 8, ZR_REG, 3, 0, SHIFT_LSR, 0, 1));
    directed_list.push_back(make_item(REQ_IMM, 0, 1, 9, 8, 0, 1, SHIFT_LSL, 0, 0));
    // Wrap to zero: Z and C together.
    directed_list.push_back(make_item(REQ_IMM, 0, 1, 10, 3, 0, 1, SHIFT_LSL, 0, 0));
    // Shift amounts at or past the word width.
    directed_list.push_back(make_item(REQ_SHIFT, 1, 1, 11, 3, 3, 0, SHIFT_LSL, 0, 63));
    // Flags left alone, and a register number past the zero register reads zero.
    directed_list.push_back(make_item(REQ_SHIFT, 1, 0, 12, 63, 3, 0, SHIFT_LSR, 0, 40));
    directed_list.push_back(make_item(REQ_SHIFT, 1, 1, 13, ZR_REG, 7, 0, SHIFT_ASR, 0, 50));
    // Shift kind three passes the operand through.
    directed_list.push_back(make_item(REQ_SHIFT, 0, 1, 14, 1, 1, 0, 2'd3, 0, 5));
    // Every extend kind with a spread of left shifts.
    directed_list.push_back(make_item(REQ_EXT, 0, 1, 15, 0, 3, 0, SHIFT_LSL, 3'd0, 4));
    directed_list.push_back(make_item(REQ_EXT, 0, 1, 16, 0, 3, 0, SHIFT_LSL, 3'd4, 0));
    directed_list.push_back(make_item(REQ_EXT, 0, 1, 17, ZR_REG, 1, 0, SHIFT_LSL, 3'd5, 3));
    directed_list.push_back(make_item(REQ_EXT, 0, 1, 18, 2, 1, 0, SHIFT_LSL, 3'd1, 1));
    directed_list.push_back(make_item(REQ_EXT, 1, 1, 19, 3, 1, 0, SHIFT_LSL, 3'd2, 2));
    // Stack pointer as destination and source.
    directed_list.push_back(make_item(REQ_EXT, 0, 1, SP_REG, SP_REG, 3, 0, SHIFT_LSL, 3'd6, 4));
    // Extend followed by the largest left shift keeps only the low bit, at the top.
    directed_list.push_back(make_item(REQ_EXT, 0, 1, 20, SP_REG, 1, 0, SHIFT_LSL, 3'd3, 63));
    // Double sign extend in word mode, with the write dropped at the zero register.
    directed_list.push_back(make_item(REQ_EXT, 1, 1, ZR_REG, 3, 3, 0, SHIFT_LSL, 3'd7, 0));
    // Supported add at the very top of the address space wraps the pc.
    directed_list.push_back(make_item(REQ_IMM, 0, 0, 21, 9, 0, 3, SHIFT_LSL, 0, 0));

    foreach (directed_list[i]) begin
      it = directed_list[i];
      it.instr_addr = 64'h4000 + 64'(i) * 4;
      if (i == 0 || i == directed_list.size() - 1) it.instr_addr = '1;
      send_item(it);
      directed_sent++;
    end

    // First profile: sender idles now and then, receiver stalls more often.
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == 300) holds_asked <= holds_asked + 1;
      send_item(random_item());
      random_sent++;
    end

    send_idle_pct <= 53;
    recv_idle_pct <= 31;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      send_item(random_item());
      random_sent++;
    end

    // Last profile runs flat out; the hold-offs here fill the block fastest.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    for (int n = 0; n < PHASE_ITEMS - 20; n++) begin
      if (n == 100 || n == 400) holds_asked <= holds_asked + 1;
      send_item(random_item());
      random_sent++;
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain: wait for every expected result, then keep the clock running so a stray
    // extra result would still be seen.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random add items under three idle profiles", directed_sent,
             random_sent);
    $display("with %0d long output hold-offs; %0d results compared", holds_done, results_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
